### src/tcw_pkg.sv
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COPY_COUNT = (ROWS - 1) * COLUMNS;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS + 1);

  // Command codes
  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Character codes and attribute reset
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_RETURN  = 8'd13;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] ATTR_RESET   = 8'h07;

  // Register index (paddr[2])
  localparam logic REG_TEXT_ATTR = 1'b0;

  // Screen write source
  localparam logic [2:0] WR_NONE     = 3'd0;
  localparam logic [2:0] WR_IN_CHAR  = 3'd1;
  localparam logic [2:0] WR_LAT_CHAR = 3'd2;
  localparam logic [2:0] WR_BLANK    = 3'd3;
  localparam logic [2:0] WR_ZERO     = 3'd4;

  // Cursor update
  localparam logic [2:0] CUR_HOLD     = 3'd0;
  localparam logic [2:0] CUR_COL0     = 3'd1;
  localparam logic [2:0] CUR_NEXT_ROW = 3'd2;
  localparam logic [2:0] CUR_COL_INC  = 3'd3;
  localparam logic [2:0] CUR_HOME     = 3'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
  } out_item_t;

  typedef struct packed {
    logic       accept;
    logic       rd_cell;
    logic       copy_rd;
    logic       sweep_clr;
    logic       sweep_inc;
    logic [2:0] wr_sel;
    logic [2:0] cur_op;
    logic       load_out;
  } tcw_cmd_t;

  typedef struct packed {
    logic wrap_pending;
    logic row_bottom;
    logic copy_end;
    logic sweep_last;
    logic out_free;
  } tcw_stat_t;

endpackage

### src/tcw_dpath.sv
module tcw_dpath import tcw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  tcw_cmd_t  cmd,
  output tcw_stat_t stat,
  input  in_item_t  in_data,
  input  logic [7:0] text_attr,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [15:0]       mem [CELL_COUNT];
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ADDR_W-1:0] sweep_r, sweep_nxt;
  logic [7:0]        char_r;
  logic              rd_ok_r;
  logic              copy_wr_r;
  logic [ADDR_W-1:0] copy_waddr_r;
  logic [15:0]       rdata_r;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r;

  logic [ADDR_W-1:0] cur_addr;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [15:0]       wdata;
  logic              idx_ok;
  logic              cell_rd;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  assign cur_addr = ADDR_W'(32'(row_r) * COLUMNS + 32'(col_r));
  assign idx_ok   = 32'(in_data.cell_index) < CELL_COUNT;
  assign cell_rd  = cmd.rd_cell && idx_ok;
  assign rd_en    = cmd.copy_rd || cell_rd;
  assign rd_addr  = cmd.copy_rd ? ADDR_W'(32'(sweep_r) + COLUMNS)
                                : ADDR_W'(in_data.cell_index);

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    unique case (cmd.cur_op)
      CUR_HOLD: ;
      CUR_COL0: col_nxt = '0;
      CUR_NEXT_ROW: begin
        row_nxt = row_r + 1'b1;
        col_nxt = '0;
      end
      CUR_COL_INC: col_nxt = col_r + 1'b1;
      CUR_HOME: begin
        row_nxt = '0;
        col_nxt = '0;
      end
      default: ;
    endcase
  end

  // Pending copy write (registered from its read) owns the port.
  always_comb begin
    we    = 1'b0;
    waddr = sweep_r;
    wdata = '0;
    if (copy_wr_r) begin
      we    = 1'b1;
      waddr = copy_waddr_r;
      wdata = rdata_r;
    end else begin
      unique case (cmd.wr_sel)
        WR_NONE: ;
        WR_IN_CHAR: begin
          we    = 1'b1;
          waddr = cur_addr;
          wdata = {text_attr, in_data.char_code};
        end
        WR_LAT_CHAR: begin
          we    = 1'b1;
          waddr = cur_addr;
          wdata = {text_attr, char_r};
        end
        WR_BLANK: begin
          we    = 1'b1;
          wdata = {text_attr, CHAR_SPACE};
        end
        WR_ZERO: we = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_comb begin
    sweep_nxt = sweep_r;
    if (cmd.sweep_clr) begin
      sweep_nxt = '0;
    end else if (cmd.sweep_inc) begin
      sweep_nxt = sweep_r + 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      sweep_r     <= '0;
      copy_wr_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      sweep_r     <= sweep_nxt;
      copy_wr_r   <= cmd.copy_rd;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    copy_waddr_r <= sweep_r;
    if (cmd.accept) begin
      char_r  <= in_data.char_code;
      rd_ok_r <= cell_rd;
    end
    if (cmd.load_out) begin
      out_data_r.cell_value <= rd_ok_r ? rdata_r : '0;
      out_data_r.cursor_row <= 5'(row_r);
      out_data_r.cursor_col <= 7'(col_r);
    end
  end

  assign stat.wrap_pending = 32'(col_r) >= COLUMNS;
  assign stat.row_bottom   = 32'(row_r) == ROWS - 1;
  assign stat.copy_end     = 32'(sweep_r) == COPY_COUNT;
  assign stat.sweep_last   = 32'(sweep_r) == CELL_COUNT - 1;
  assign stat.out_free     = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### src/tcw_ctrl.sv
module tcw_ctrl import tcw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_item_t  in_data,
  output logic      in_stall,
  input  tcw_stat_t stat,
  output tcw_cmd_t  cmd
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_CLEAR  = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_FILL   = 3'd4;
  localparam logic [2:0] S_PUT    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       put_after_r, put_after_nxt;

  assign in_stall = state_r != S_IDLE;

  always_comb begin
    state_nxt     = state_r;
    put_after_nxt = put_after_r;
    cmd           = '0;
    cmd.wr_sel    = WR_NONE;
    cmd.cur_op    = CUR_HOLD;
    unique case (state_r)
      S_INIT: begin
        cmd.wr_sel = WR_ZERO;
        if (stat.sweep_last) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.sweep_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DONE;
          priority if (in_data.cmd == CMD_PUT) begin
            priority if (in_data.char_code == CHAR_NEWLINE) begin
              if (stat.row_bottom) begin
                cmd.cur_op    = CUR_COL0;
                cmd.sweep_clr = 1'b1;
                put_after_nxt = 1'b0;
                state_nxt     = S_SCROLL;
              end else begin
                cmd.cur_op = CUR_NEXT_ROW;
              end
            end else if (in_data.char_code == CHAR_RETURN) begin
              cmd.cur_op = CUR_COL0;
            end else if (stat.wrap_pending) begin
              if (stat.row_bottom) begin
                cmd.cur_op    = CUR_COL0;
                cmd.sweep_clr = 1'b1;
                put_after_nxt = 1'b1;
                state_nxt     = S_SCROLL;
              end else begin
                cmd.cur_op = CUR_NEXT_ROW;
                state_nxt  = S_PUT;
              end
            end else begin
              cmd.wr_sel = WR_IN_CHAR;
              cmd.cur_op = CUR_COL_INC;
            end
          end else if (in_data.cmd == CMD_CLEAR) begin
            cmd.sweep_clr = 1'b1;
            cmd.cur_op    = CUR_HOME;
            state_nxt     = S_CLEAR;
          end else if (in_data.cmd == CMD_READ) begin
            cmd.rd_cell = 1'b1;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_CLEAR: begin
        cmd.wr_sel = WR_BLANK;
        if (stat.sweep_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.sweep_inc = 1'b1;
        end
      end
      S_SCROLL: begin
        // last cycle only drains the copy write
        if (stat.copy_end) begin
          state_nxt = S_FILL;
        end else begin
          cmd.copy_rd   = 1'b1;
          cmd.sweep_inc = 1'b1;
        end
      end
      S_FILL: begin
        cmd.wr_sel = WR_BLANK;
        if (stat.sweep_last) begin
          state_nxt = put_after_r ? S_PUT : S_DONE;
        end else begin
          cmd.sweep_inc = 1'b1;
        end
      end
      S_PUT: begin
        cmd.wr_sel = WR_LAT_CHAR;
        cmd.cur_op = CUR_COL_INC;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      put_after_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      put_after_r <= put_after_nxt;
    end
  end

endmodule

### src/text_console_writer.sv
// Channel | Ports                                   | Transfer when
// --------+-----------------------------------------+-------------------------------
// input   | in_valid, in_stall, in_data (in_item_t) | in_valid && !in_stall
// result  | out_valid, out_stall, out_data          | out_valid && !out_stall
// config  | psel, penable, pwrite, paddr, pwdata    | psel && penable && pwrite
//
// Flow: plain put, CR, LF without scroll, read and unused code go from IDLE
//   to DONE; a put after a pending wrap passes through PUT. Clear walks every cell.
//   A scroll copies COPY_COUNT cells up, then blanks COLUMNS cells: the store has
//   one write port, so copying and blanking move one cell per cycle.
// Reset: a pass writes zero to every cell, with in_stall high throughout;
//   config writes are taken during it.
// Stalls: a finished result sits in the output register while the next
//   transfer is accepted; the block only waits if that register is still full.
module text_console_writer import tcw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] text_attr_r, text_attr_nxt;
  logic       cfg_wr;
  tcw_cmd_t   cmd;
  tcw_stat_t  stat;

  // Single register, decoded on paddr[2]; byte lanes below are ignored.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_TEXT_ATTR) ? {24'd0, text_attr_r} : '0;

  always_comb begin
    text_attr_nxt = text_attr_r;
    if (cfg_wr && paddr[2] == REG_TEXT_ATTR) begin
      text_attr_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_attr_r <= ATTR_RESET;
    end else begin
      text_attr_r <= text_attr_nxt;
    end
  end

  // Sequencer: decodes the command, walks the store for clear and scroll.
  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Screen store, cursor, sweep counter and result register.
  tcw_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .text_attr (text_attr_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Store init pass must hold off input transfers.
  a_init_stalls: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken during store init");

  // One item at a time: a transfer is always followed by a busy cycle.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transfer straight after the first");

  // Reported cursor stays on screen (column may show the pending wrap).
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_data.cursor_col) <= COLUMNS &&
                   32'(out_data.cursor_row) < ROWS))
    else $error("cursor off screen");

endmodule
